// ===== hdl/wgm_pkg.sv =====
// Package: shared types and constants of the wildcard glob matcher.
`timescale 1ns / 1ps

package wgm_pkg;

  localparam int unsigned PatternMax = 32;
  localparam int unsigned LenW       = $clog2(PatternMax + 1);
  localparam int unsigned AddrW      = (PatternMax > 1) ? $clog2(PatternMax) : 1;

  localparam logic [7:0] ChAnyOne = 8'd63;  // '?'
  localparam logic [7:0] ChAnyRun = 8'd42;  // '*'

  typedef enum logic [1:0] {
    KindClear  = 2'd0,
    KindAppend = 2'd1,
    KindText   = 2'd2,
    KindEnd    = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] ch;
  } req_t;

  typedef struct packed {
    logic matched;
    logic overflow;
  } res_t;

  // Pattern view handed to the live-set logic.
  typedef struct packed {
    logic [PatternMax-1:0][7:0] bytes;
    logic [PatternMax-1:0]      star;
    logic [PatternMax-1:0]      used;
    logic [PatternMax:0]        restart;   // live set to load on a text restart
    logic [LenW-1:0]            len;
    logic                       overflow;
  } pat_t;

endpackage

// ===== hdl/wildcard_glob_matcher.sv =====
// Top level: whole-string glob matcher with streamed pattern and text.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+------------------------------
//   in      | to block  | in_valid_i/in_stall_o | in_req_i  (kind, ch)
//   out     | from block| out_valid_o/out_stall_i| out_res_o (matched, overflow)
//
// One request per cycle sustained while in_stall_o is low: a request is held
// in the input register, then the live-set update (lane compare + star
// closure scan) retires it. End-of-text requests load the result register,
// from which the verdict leaves.
// Reset empties the pattern, clears overflow and sets only position 0 live.
// An end request waits in the input register while the result register is
// full and stalled; in_stall_o rises only then.
`timescale 1ns / 1ps

module wildcard_glob_matcher (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  wgm_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output wgm_pkg::res_t out_res_o
);

  logic          in_vld_q, in_vld_d;
  wgm_pkg::req_t in_q;
  logic          in_accept;
  logic          fire;
  logic          fire_end;
  logic          out_vld_q, out_vld_d;
  wgm_pkg::res_t out_q;
  wgm_pkg::pat_t pat;
  wgm_pkg::res_t verdict;

  // A held request retires unless it is an end whose result slot is blocked.
  assign fire      = in_vld_q &&
                     ((in_q.kind != wgm_pkg::KindEnd) || !out_vld_q || !out_stall_i);
  assign fire_end  = fire && (in_q.kind == wgm_pkg::KindEnd);
  assign in_stall_o = in_vld_q && !fire;
  assign in_accept = in_valid_i && !in_stall_o;

  assign in_vld_d  = in_accept || (in_vld_q && !fire);
  assign out_vld_d = fire_end || (out_vld_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_req_i;
    end
    if (fire_end) begin
      out_q <= verdict;
    end
  end

  wgm_pattern u_pattern (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .req_i  (in_q),
    .pat_o  (pat)
  );

  wgm_live u_live (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .req_i     (in_q),
    .pat_i     (pat),
    .verdict_o (verdict)
  );

  assign out_valid_o = out_vld_q;
  assign out_res_o   = out_q;

endmodule

// ===== hdl/wgm_pattern.sv =====
// Pattern store, length, star mask and restart live set.
`timescale 1ns / 1ps

module wgm_pattern (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  wgm_pkg::req_t req_i,
  output wgm_pkg::pat_t pat_o
);

  logic [wgm_pkg::PatternMax-1:0][7:0] store_q;
  logic [wgm_pkg::PatternMax-1:0]      star_q;
  logic [wgm_pkg::LenW-1:0]            len_q, len_d;
  logic                                ovf_q, ovf_d;
  logic [wgm_pkg::PatternMax:0]        init_q, init_d;
  logic                                room;
  logic                                wr_en;
  logic                                is_star;
  logic [wgm_pkg::AddrW-1:0]           wr_addr;
  logic [wgm_pkg::PatternMax-1:0]      used;

  assign room    = (len_q != wgm_pkg::LenW'(wgm_pkg::PatternMax));
  assign is_star = (req_i.ch == wgm_pkg::ChAnyRun);
  assign wr_addr = len_q[wgm_pkg::AddrW-1:0];
  assign wr_en   = fire_i && (req_i.kind == wgm_pkg::KindAppend) && room;

  always_comb begin
    len_d  = len_q;
    ovf_d  = ovf_q;
    init_d = init_q;
    if (fire_i) begin
      case (req_i.kind)
        wgm_pkg::KindClear: begin
          len_d  = '0;
          ovf_d  = 1'b0;
          init_d = (wgm_pkg::PatternMax + 1)'(1);
        end
        wgm_pkg::KindAppend: begin
          if (room) begin
            len_d = len_q + 1'b1;
            // leading-star run grows only while every byte so far is a star
            if (init_q[len_q] && is_star) begin
              init_d[len_q + 1'b1] = 1'b1;
            end
          end else begin
            ovf_d = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      ovf_q  <= 1'b0;
      init_q <= (wgm_pkg::PatternMax + 1)'(1);
    end else begin
      len_q  <= len_d;
      ovf_q  <= ovf_d;
      init_q <= init_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[wr_addr] <= req_i.ch;
      star_q[wr_addr]  <= is_star;
    end
  end

  always_comb begin
    for (int i = 0; i < wgm_pkg::PatternMax; i++) begin
      used[i] = (wgm_pkg::LenW'(i) < len_q);
    end
  end

  assign pat_o.bytes    = store_q;
  assign pat_o.star     = star_q;
  assign pat_o.used     = used;
  assign pat_o.restart  = init_d;
  assign pat_o.len      = len_q;
  assign pat_o.overflow = ovf_q;

endmodule

// ===== hdl/wgm_live.sv =====
// Live pattern position set: per-lane step plus prefix star closure.
`timescale 1ns / 1ps

module wgm_live (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  wgm_pkg::req_t req_i,
  input  wgm_pkg::pat_t pat_i,
  output wgm_pkg::res_t verdict_o
);

  localparam int unsigned LiveW = wgm_pkg::PatternMax + 1;

  logic [LiveW-1:0]                 live_q, live_d;
  logic [LiveW-1:0]                 gen;
  logic [LiveW-1:0]                 closed;
  logic [wgm_pkg::PatternMax-1:0]   hold, adv, prop;

  // Log-depth scan: bit j is live if some i <= j is generated and all of
  // positions i..j-1 are stars (same shape as a carry-lookahead tree).
  function automatic logic [LiveW-1:0] closure(input logic [LiveW-1:0] g,
                                               input logic [LiveW-1:0] p);
    logic [LiveW-1:0] gc, pc, gn, pn;
    gc = g;
    pc = p;
    for (int d = 1; d < LiveW; d = d * 2) begin
      gn = gc;
      pn = pc;
      for (int j = 0; j < LiveW; j++) begin
        if (j >= d) begin
          gn[j] = gc[j] | (pc[j] & gc[j-d]);
          pn[j] = pc[j] & pc[j-d];
        end
      end
      gc = gn;
      pc = pn;
    end
    return gc;
  endfunction

  always_comb begin
    for (int i = 0; i < wgm_pkg::PatternMax; i++) begin
      hold[i] = live_q[i] && pat_i.used[i] && pat_i.star[i];
      adv[i]  = live_q[i] && pat_i.used[i] && !pat_i.star[i] &&
                ((pat_i.bytes[i] == wgm_pkg::ChAnyOne) || (pat_i.bytes[i] == req_i.ch));
      prop[i] = pat_i.used[i] && pat_i.star[i];
    end
  end

  assign gen    = {adv, 1'b0} | {1'b0, hold};
  assign closed = closure(gen, {prop, 1'b0});

  always_comb begin
    live_d = live_q;
    if (fire_i) begin
      case (req_i.kind)
        wgm_pkg::KindText: live_d = closed;
        default:           live_d = pat_i.restart;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= LiveW'(1);
    end else begin
      live_q <= live_d;
    end
  end

  assign verdict_o.matched  = !pat_i.overflow && live_q[pat_i.len];
  assign verdict_o.overflow = pat_i.overflow;

endmodule
